/* hdl/qgpt_pkg.sv */
// qgpt_pkg: shared types and constants of the two-qubit gene amplitude table
// used by every file under hdl except qgpt_ram; depends on nothing
package qgpt_pkg;

  localparam int POPULATION = 16;
  localparam int GENES      = 128;
  localparam int ENTRIES    = POPULATION * GENES;
  localparam int ADDR_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int OP_W   = 2;
  localparam int IND_W  = 4;
  localparam int GENE_W = 7;
  localparam int RND_W  = 16;
  localparam int PAIR_W = 2;
  localparam int AMP_W  = 16;
  localparam int PROD_W = 2 * AMP_W;
  localparam int ACC_W  = 32;
  localparam int ARG_W  = 31;
  localparam int ROW_W  = 4 * AMP_W;

  localparam logic [AMP_W-1:0] AMP_ONE   = 16'h8000;
  localparam logic [AMP_W-1:0] AMP_HALF  = 16'h4000;
  localparam logic [ACC_W-1:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [PROD_W:0]  ROUND_BIAS = 33'd16384;

  typedef enum logic [OP_W-1:0] {
    OP_OBSERVE = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_INIT    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_OBS_SQ,
    S_OBS_ACC,
    S_OBS_CMP,
    S_UPD_SCALE,
    S_UPD_ROUND,
    S_UPD_SQ,
    S_UPD_ACC,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_WRITE,
    S_DONE
  } state_t;

  // commands to the shared multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

/* hdl/qgpt_if.sv */
// qgpt_if: valid/ready channel interfaces for request and result beats
// depends on qgpt_pkg
interface qgpt_in_if import qgpt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IND_W-1:0]  individual;
  logic [GENE_W-1:0] gene;
  logic [RND_W-1:0]  rand_fraction;
  logic [PAIR_W-1:0] best_pair;

  modport source (output valid, op, individual, gene, rand_fraction, best_pair,
                  input ready);
  modport sink   (input valid, op, individual, gene, rand_fraction, best_pair,
                  output ready);
endinterface

interface qgpt_out_if import qgpt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PAIR_W-1:0] sample;
  logic [AMP_W-1:0]  amp_00;
  logic [AMP_W-1:0]  amp_01;
  logic [AMP_W-1:0]  amp_10;
  logic [AMP_W-1:0]  amp_11;

  modport source (output valid, sample, amp_00, amp_01, amp_10, amp_11,
                  input ready);
  modport sink   (input valid, sample, amp_00, amp_01, amp_10, amp_11,
                  output ready);
endinterface

/* hdl/qgpt_ram.sv */
// qgpt_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module qgpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/qgpt_mac.sv */
// qgpt_mac: shared 16x16 multiplier with registered product and accumulator
// depends on qgpt_pkg
module qgpt_mac import qgpt_pkg::*; (
  input  logic              clk,
  input  mac_ctrl_t         ctrl,
  input  logic [AMP_W-1:0]  op_a,
  input  logic [AMP_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod,
  output logic [ACC_W-1:0]  acc
);

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (ctrl.mul) begin
      prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);
    end
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (ctrl.acc) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

/* hdl/qgpt_sqrt.sv */
// qgpt_sqrt: digit-by-digit integer square root, two argument bits per cycle
// depends on qgpt_pkg
module qgpt_sqrt import qgpt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ARG_W-1:0] arg,
  output sqrt_stat_t       stat,
  output logic [AMP_W-1:0] root
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] v_r, v_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic [31:0] trial;

  always_comb begin
    trial    = res_r + bit_r;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = {1'b0, arg};
      res_nxt  = '0;
      bit_nxt  = 32'h4000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      // last digit pair
      if (bit_r == 32'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = res_r[AMP_W-1:0];

endmodule

/* hdl/quantum_gene_pair_table.sv */
// quantum_gene_pair_table: top level, sequencer around the amplitude RAM,
// shared multiply-accumulate unit and square-root unit
// depends on qgpt_pkg, qgpt_if, qgpt_ram, qgpt_mac, qgpt_sqrt
//
// Usage: a request beat on in_ch names an entry (individual, gene) and an
// op: observe, update or initialize. Each request gives exactly one result
// beat on out_ch with the sample and the entry's four Q1.15 amplitudes.
// cfg_we/cfg_wdata load the contraction factor; write it only while idle.
// in_ch.ready is high only while the sequencer is idle, so one request is
// worked on at a time. Initialize writes the entry straight from idle; op
// three or an entry out of range gives a zero result and leaves the table;
// observe squares and sums amplitudes through the shared multiplier, testing
// at most three basis values; update contracts every amplitude but the best
// through the shared multiplier, then rebuilds the best with the square root.
// A finished result sits in an output register, so a new request is taken
// while it waits; a stalled receiver holds the sequencer in its last step
// only once a second result is ready. Reset empties the output register,
// sets the contraction to 1.0 and leaves the table contents undefined:
// every entry must be initialized before it is observed or updated.
module quantum_gene_pair_table import qgpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  qgpt_in_if.sink           in_ch,
  qgpt_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [AMP_W-1:0]  cfg_wdata
);

  state_t            state_r, state_nxt;
  logic [AMP_W-1:0]  contraction_r;
  op_t               op_r, op_nxt;
  logic [PAIR_W-1:0] best_r, best_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [AMP_W-1:0]  amp_r [4];
  logic [AMP_W-1:0]  amp_nxt [4];
  logic [PAIR_W-1:0] sample_r, sample_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PAIR_W-1:0] out_sample_r;
  logic [AMP_W-1:0]  out_amp_r [4];

  logic              accept;
  logic              in_range;
  logic              out_load;
  logic [ADDR_W-1:0] in_addr;
  logic              ram_we;
  logic              ram_re;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  mac_ctrl_t         mac_ctrl;
  logic [AMP_W-1:0]  mac_a, mac_b;
  logic [PROD_W-1:0] mac_prod;
  logic [ACC_W-1:0]  mac_acc;
  logic              sq_start;
  logic [ARG_W-1:0]  sq_arg;
  sqrt_stat_t        sq_stat;
  logic [AMP_W-1:0]  sq_root;
  logic [PROD_W:0]   round_sum;
  logic [17:0]       scaled;
  logic [AMP_W-1:0]  scaled_sat;
  logic [ACC_W-1:0]  r_q30;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_range = (int'(in_ch.individual) < POPULATION) && (int'(in_ch.gene) < GENES);
  assign in_addr  = ADDR_W'(ADDR_W'(in_ch.individual) * ADDR_W'(GENES))
                  + ADDR_W'(in_ch.gene);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // round half up, then saturate at 1.0
  assign round_sum  = {1'b0, mac_prod} + ROUND_BIAS;
  assign scaled     = round_sum[PROD_W:15];
  assign scaled_sat = (scaled > 18'(AMP_ONE)) ? AMP_ONE : scaled[AMP_W-1:0];
  assign r_q30      = ACC_W'({rnd_r, 14'b0});
  assign sq_arg     = (mac_acc >= ONE_Q30) ? '0 : ARG_W'(ONE_Q30 - mac_acc);
  assign ram_wdata  = {amp_r[3], amp_r[2], amp_r[1], amp_r[0]};

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    best_nxt   = best_r;
    rnd_nxt    = rnd_r;
    addr_nxt   = addr_r;
    k_nxt      = k_r;
    sample_nxt = sample_r;
    for (int i = 0; i < 4; i++) begin
      amp_nxt[i] = amp_r[i];
    end
    mac_ctrl  = '0;
    mac_a     = amp_r[k_r];
    mac_b     = amp_r[k_r];
    sq_start  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = op_t'(in_ch.op);
          best_nxt   = in_ch.best_pair;
          rnd_nxt    = in_ch.rand_fraction;
          addr_nxt   = in_addr;
          sample_nxt = '0;
          if (op_t'(in_ch.op) == OP_NONE || !in_range) begin
            for (int i = 0; i < 4; i++) begin
              amp_nxt[i] = '0;
            end
            state_nxt = S_DONE;
          end else if (op_t'(in_ch.op) == OP_INIT) begin
            for (int i = 0; i < 4; i++) begin
              amp_nxt[i] = AMP_HALF;
            end
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        amp_nxt[0] = ram_rdata[15:0];
        amp_nxt[1] = ram_rdata[31:16];
        amp_nxt[2] = ram_rdata[47:32];
        amp_nxt[3] = ram_rdata[63:48];
        k_nxt        = '0;
        mac_ctrl.clr = 1'b1;
        state_nxt    = (op_r == OP_OBSERVE) ? S_OBS_SQ : S_UPD_SCALE;
      end
      S_OBS_SQ: begin
        mac_ctrl.mul = 1'b1;
        state_nxt    = S_OBS_ACC;
      end
      S_OBS_ACC: begin
        mac_ctrl.acc = 1'b1;
        state_nxt    = S_OBS_CMP;
      end
      S_OBS_CMP: begin
        if (r_q30 < mac_acc) begin
          sample_nxt = k_r;
          state_nxt  = S_DONE;
        end else if (k_r == 2'd2) begin
          sample_nxt = 2'd3;
          state_nxt  = S_DONE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_OBS_SQ;
        end
      end
      S_UPD_SCALE: begin
        if (k_r == best_r) begin
          // best amplitude is rebuilt by the square root
          k_nxt     = k_r + 2'd1;
          state_nxt = (k_r == 2'd3) ? S_SQRT_GO : S_UPD_SCALE;
        end else begin
          mac_a        = contraction_r;
          mac_ctrl.mul = 1'b1;
          state_nxt    = S_UPD_ROUND;
        end
      end
      S_UPD_ROUND: begin
        amp_nxt[k_r] = scaled_sat;
        state_nxt    = S_UPD_SQ;
      end
      S_UPD_SQ: begin
        mac_ctrl.mul = 1'b1;
        state_nxt    = S_UPD_ACC;
      end
      S_UPD_ACC: begin
        mac_ctrl.acc = 1'b1;
        k_nxt        = k_r + 2'd1;
        state_nxt    = (k_r == 2'd3) ? S_SQRT_GO : S_UPD_SCALE;
      end
      S_SQRT_GO: begin
        sq_start  = 1'b1;
        state_nxt = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sq_stat.done) begin
          amp_nxt[best_r] = sq_root;
          state_nxt       = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      contraction_r <= AMP_ONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        contraction_r <= cfg_wdata;
      end
    end
    op_r     <= op_nxt;
    best_r   <= best_nxt;
    rnd_r    <= rnd_nxt;
    addr_r   <= addr_nxt;
    k_r      <= k_nxt;
    sample_r <= sample_nxt;
    for (int i = 0; i < 4; i++) begin
      amp_r[i] <= amp_nxt[i];
    end
    if (out_load) begin
      out_sample_r <= sample_r;
      for (int i = 0; i < 4; i++) begin
        out_amp_r[i] <= amp_r[i];
      end
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;
  assign out_ch.amp_00 = out_amp_r[0];
  assign out_ch.amp_01 = out_amp_r[1];
  assign out_ch.amp_10 = out_amp_r[2];
  assign out_ch.amp_11 = out_amp_r[3];

  qgpt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  qgpt_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .prod (mac_prod),
    .acc  (mac_acc)
  );

  qgpt_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .arg   (sq_arg),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  // root unit is running once started
  assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |=> sq_stat.busy)
    else $error("square-root unit not busy after start");

  // a pending result beat is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ch.ready) |=> state_r == S_DONE)
    else $error("sequencer left final step while result beat pending");

  // only observe produces a nonzero sample
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r != OP_OBSERVE) |-> sample_r == '0)
    else $error("nonzero sample for a non-observe op");

  // initialize writes four halves
  assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && op_r == OP_INIT) |-> ram_wdata == {4{AMP_HALF}})
    else $error("initialize wrote wrong amplitudes");

  // square root never exceeds 1.0 when it finishes
  assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> sq_root <= AMP_ONE)
    else $error("square root above 1.0");

endmodule

/* tb/tb_quantum_gene_pair_table.sv */
// tb_quantum_gene_pair_table: self-checking bench for the two-qubit gene amplitude table
// walks a directed table, then random phases of observe/update/initialize/op-three beats against
// its own predictor; depends on qgpt_pkg, qgpt_if and quantum_gene_pair_table
module tb_quantum_gene_pair_table import qgpt_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HALF_AMP      = 16384;
  localparam int          FULL_AMP      = 32768;
  localparam int          PHASES        = 7;
  localparam int          PHASE_BEATS   = 250;
  localparam int          CHUNK_BEATS   = 50;
  localparam int          HOT_ENTRIES   = 6;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int          SETTLE_CYCLES = 40;
  localparam int unsigned WATCHDOG_NS   = 20_000_000;

  typedef struct packed {
    op_t               op;
    logic [IND_W-1:0]  individual;
    logic [GENE_W-1:0] gene;
    logic [RND_W-1:0]  rand_fraction;
    logic [PAIR_W-1:0] best_pair;
  } gene_req_t;

  typedef struct packed {
    logic [PAIR_W-1:0]     sample;
    logic [3:0][AMP_W-1:0] amps;
  } gene_result_t;

  typedef struct {
    bit               set_ctr;
    logic [AMP_W-1:0] ctr;
    gene_req_t        req;
    bit               typed;
    gene_result_t     want;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [AMP_W-1:0] cfg_wdata;

  qgpt_in_if  in_ch ();
  qgpt_out_if out_ch ();

  quantum_gene_pair_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [3:0][AMP_W-1:0] amp_table [ENTRIES];
  bit                    entry_live [ENTRIES];
  logic [AMP_W-1:0]      contraction;

  gene_result_t expected_results [$];
  stim_row_t    script [$];
  int unsigned  mismatches;
  int unsigned  hold_cycles_req;
  bit           tx_idle_on;
  bit           rx_idle_on;

  logic [AMP_W-1:0] phase_ctr [PHASES] = '{16'd32768, 16'd29491, 16'd0, 16'd31130,
                                           16'hFFFF, 16'd26214, 16'd30000};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("quantum_gene_pair_table verification failed");
    $finish;
  end

  function automatic logic [AMP_W-1:0] floor_root(input logic [31:0] v);
    logic [AMP_W-1:0] root;
    logic [AMP_W-1:0] trial;
    root = '0;
    for (int b = AMP_W - 1; b >= 0; b--) begin
      trial = root | (AMP_W'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(v)) root = trial;
    end
    return root;
  endfunction

  // round half up, then clip at 1.0
  function automatic logic [AMP_W-1:0] contract_amp(input logic [AMP_W-1:0] a);
    logic [63:0] p;
    p = (64'(contraction) * 64'(a) + 64'd16384) >> 15;
    return (p > 64'(AMP_ONE)) ? AMP_ONE : p[AMP_W-1:0];
  endfunction

  function automatic gene_result_t predict_beat(input gene_req_t r);
    gene_result_t     res;
    int unsigned      slot;
    logic [63:0]      level;
    logic [63:0]      acc;
    logic [63:0]      sum;
    logic [AMP_W-1:0] amp;
    bit               found;
    res = '0;
    if (r.op == OP_NONE || r.individual >= POPULATION || r.gene >= GENES) return res;
    slot = r.individual * GENES + r.gene;
    case (r.op)
      OP_INIT: begin
        for (int k = 0; k < 4; k++) amp_table[slot][k] = AMP_HALF;
        entry_live[slot] = 1'b1;
      end
      OP_OBSERVE: begin
        level = 64'(r.rand_fraction) << 14;
        acc = '0;
        found = 1'b0;
        res.sample = 2'd3;
        for (int k = 0; k < 3; k++) begin
          acc += 64'(amp_table[slot][k]) * 64'(amp_table[slot][k]);
          if (!found && level < acc) begin
            res.sample = PAIR_W'(k);
            found = 1'b1;
          end
        end
      end
      default: begin
        sum = '0;
        for (int k = 0; k < 4; k++) begin
          if (k != int'(r.best_pair)) begin
            amp = contract_amp(amp_table[slot][k]);
            amp_table[slot][k] = amp;
            sum += 64'(amp) * 64'(amp);
          end
        end
        // a sum past 1.0 clips the root argument to zero
        amp_table[slot][r.best_pair] =
          floor_root((sum >= 64'(ONE_Q30)) ? 32'd0 : 32'(64'(ONE_Q30) - sum));
      end
    endcase
    res.amps = amp_table[slot];
    return res;
  endfunction

  task automatic add_row(input bit set_ctr, input int ctr, input op_t op, input int ind,
                         input int gene, input int rnd, input int best, input bit typed,
                         input int smp, input int a00, input int a01, input int a10,
                         input int a11);
    stim_row_t row;
    row.set_ctr           = set_ctr;
    row.ctr               = AMP_W'(ctr);
    row.req.op            = op;
    row.req.individual    = IND_W'(ind);
    row.req.gene          = GENE_W'(gene);
    row.req.rand_fraction = RND_W'(rnd);
    row.req.best_pair     = PAIR_W'(best);
    row.typed             = typed;
    row.want.sample       = PAIR_W'(smp);
    row.want.amps         = {AMP_W'(a11), AMP_W'(a10), AMP_W'(a01), AMP_W'(a00)};
    script.push_back(row);
  endtask

  // valid stays high between back-to-back beats, so it is only lowered for a gap
  task automatic send_req(input gene_req_t r, input int unsigned gap, input bit typed,
                          input gene_result_t want);
    gene_result_t predicted;
    if (gap != 0) begin
      if (in_ch.valid) in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= r.op;
    in_ch.individual    <= r.individual;
    in_ch.gene          <= r.gene;
    in_ch.rand_fraction <= r.rand_fraction;
    in_ch.best_pair     <= r.best_pair;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_beat(r);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_contraction(input logic [AMP_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    contraction = v;
  endtask

  task automatic check_beat();
    gene_result_t          want;
    logic [3:0][AMP_W-1:0] got;
    if (expected_results.size() == 0) begin
      mismatches++;
      $error("result beat with nothing expected");
      return;
    end
    want = expected_results.pop_front();
    got  = {out_ch.amp_11, out_ch.amp_10, out_ch.amp_01, out_ch.amp_00};
    if (out_ch.sample !== want.sample) begin
      mismatches++;
      $error("sample mismatch: expected %0d, got %0d", want.sample, out_ch.sample);
    end
    for (int k = 0; k < 4; k++) begin
      if (got[k] !== want.amps[k]) begin
        mismatches++;
        $error("amp_%0d%0d mismatch: expected %0d, got %0d", k / 2, k % 2,
               want.amps[k], got[k]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_beat();
  end

  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles_req != 0) begin
        stall = hold_cycles_req;
        hold_cycles_req = 0;
      end else if (rx_idle_on) begin
        stall = $urandom_range(0, 19);
      end else begin
        stall = 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : request_source
    gene_req_t         req;
    gene_result_t      no_want;
    logic [IND_W-1:0]  hot_ind [HOT_ENTRIES];
    logic [GENE_W-1:0] hot_gene [HOT_ENTRIES];
    int unsigned       pick;
    int unsigned       roll;
    int unsigned       slot;

    no_want         = '0;
    mismatches      = 0;
    hold_cycles_req = 0;
    tx_idle_on      = 1'b0;
    rx_idle_on      = 1'b0;
    contraction     = AMP_ONE;
    foreach (entry_live[i]) entry_live[i] = 1'b0;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_NONE;
    in_ch.individual    <= '0;
    in_ch.gene          <= '0;
    in_ch.rand_fraction <= '0;
    in_ch.best_pair     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: sample thresholds, reset contraction, zero and full contraction,
    // contraction above 1.0, negative root argument, op three
    add_row(0, 0, OP_INIT, 0, 0, 'h0000, 0, 1, 0, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(0, 0, OP_OBSERVE, 0, 0, 'h0000, 0, 1, 0, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(0, 0, OP_OBSERVE, 0, 0, 'h4000, 0, 1, 1, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(0, 0, OP_OBSERVE, 0, 0, 'h8000, 0, 1, 2, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(0, 0, OP_OBSERVE, 0, 0, 'hFFFF, 0, 1, 3, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(0, 0, OP_NONE, 15, 127, 'hFFFF, 3, 1, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_INIT, 15, 127, 'hFFFF, 3, 1, 0, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(0, 0, OP_UPDATE, 15, 127, 'h1234, 3, 1, 0, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(1, 29491, OP_UPDATE, 15, 127, 'h0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_UPDATE, 15, 127, 'h0000, 1, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_UPDATE, 15, 127, 'h0000, 2, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_OBSERVE, 15, 127, 'h7FFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_INIT, 3, 5, 'h0000, 0, 1, 0, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(1, 0, OP_UPDATE, 3, 5, 'h0000, 2, 1, 0, 0, 0, FULL_AMP, 0);
    add_row(0, 0, OP_OBSERVE, 3, 5, 'h0000, 0, 1, 2, 0, 0, FULL_AMP, 0);
    add_row(0, 0, OP_OBSERVE, 3, 5, 'hFFFF, 0, 1, 2, 0, 0, FULL_AMP, 0);
    add_row(1, 'hFFFF, OP_UPDATE, 3, 5, 'h0000, 0, 1, 0, 0, 0, FULL_AMP, 0);
    add_row(0, 0, OP_INIT, 10, 64, 'h0000, 0, 1, 0, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(0, 0, OP_UPDATE, 10, 64, 'h0000, 1, 1, 0, FULL_AMP, 0, FULL_AMP, FULL_AMP);
    add_row(0, 0, OP_OBSERVE, 10, 64, 'h0000, 0, 1, 0, FULL_AMP, 0, FULL_AMP, FULL_AMP);
    add_row(1, 32768, OP_UPDATE, 10, 64, 'h0000, 3, 1, 0, FULL_AMP, 0, FULL_AMP, 0);
    add_row(1, 16384, OP_INIT, 7, 100, 'h0000, 0, 1, 0, HALF_AMP, HALF_AMP, HALF_AMP, HALF_AMP);
    add_row(0, 0, OP_UPDATE, 7, 100, 'h0000, 2, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_OBSERVE, 7, 100, 'hC000, 1, 0, 0, 0, 0, 0, 0);

    foreach (script[i]) begin
      if (script[i].set_ctr) write_contraction(script[i].ctr);
      send_req(script[i].req, 0, script[i].typed, script[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_contraction((ph == PHASES - 1) ? AMP_W'($urandom_range(16384, 32768))
                                           : phase_ctr[ph]);
      // a few hot entries per phase so updates chain on the same amplitudes
      for (int h = 0; h < HOT_ENTRIES; h++) begin
        hot_ind[h]  = IND_W'($urandom);
        hot_gene[h] = GENE_W'($urandom);
      end
      if (ph == 1) hold_cycles_req = LONG_HOLD;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n % CHUNK_BEATS == 0) begin
          tx_idle_on = ($urandom_range(0, 2) != 0);
          rx_idle_on = ($urandom_range(0, 2) != 0);
          // keep offering beats while the receiver holds off
          if (ph == 1 && n == 0) tx_idle_on = 1'b0;
        end
        if ($urandom_range(0, 4) != 0) begin
          pick           = $urandom_range(0, HOT_ENTRIES - 1);
          req.individual = hot_ind[pick];
          req.gene       = hot_gene[pick];
        end else begin
          req.individual = IND_W'($urandom);
          req.gene       = GENE_W'($urandom);
        end
        req.rand_fraction = RND_W'($urandom_range(0, 65535));
        req.best_pair     = PAIR_W'($urandom_range(0, 3));
        slot = req.individual * GENES + req.gene;
        roll = $urandom_range(0, 99);
        if (!entry_live[slot]) req.op = (roll < 90) ? OP_INIT : OP_NONE;
        else if (roll < 45)    req.op = OP_OBSERVE;
        else if (roll < 85)    req.op = OP_UPDATE;
        else if (roll < 93)    req.op = OP_INIT;
        else                   req.op = OP_NONE;
        send_req(req, tx_idle_on ? $urandom_range(0, 19) : 0, 1'b0, no_want);
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("quantum_gene_pair_table verification clean");
    end else begin
      $display("quantum_gene_pair_table verification failed");
    end
    $finish;
  end

endmodule

/* quantum_gene_pair_table.f */
hdl/qgpt_pkg.sv
hdl/qgpt_if.sv
hdl/qgpt_ram.sv
hdl/qgpt_mac.sv
hdl/qgpt_sqrt.sv
hdl/quantum_gene_pair_table.sv
tb/tb_quantum_gene_pair_table.sv
